// ----- hdl/pba_pkg.sv -----
// Package for the page bitmap allocator: sizes, request and status codes,
// sequencer states and the bitmap RAM request struct.
// No dependencies.
package pba_pkg;

  localparam int unsigned PAGE_COUNT  = 4096;
  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned WORD_COUNT  = (PAGE_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WORD_IDX_W  = $clog2(WORD_COUNT);
  localparam int unsigned BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int unsigned PAGE_IDX_W  = WORD_IDX_W + BIT_IDX_W;
  localparam int unsigned PAGE_OFS_W  = $clog2(PAGE_BYTES);
  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned PFN_W       = ADDR_W - PAGE_OFS_W;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [CNT_W-1:0]     PAGE_COUNT_MAX = CNT_W'(PAGE_COUNT);
  localparam logic [WORD_BITS-1:0] WORD_ONES      = '1;

  typedef enum logic [1:0] {
    MODE_MARK   = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_ALLOC  = 2'd2,
    MODE_REGION = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_RANGE   = 2'd1,
    STATUS_NO_FREE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_READ   = 2'd1,
    ST_MODIFY = 2'd2,
    ST_DONE   = 2'd3
  } state_e;

  // register index on the APB port
  localparam logic REG_PAGE_COUNT = 1'b0;

  typedef struct packed {
    logic                  rd_en;
    logic [WORD_IDX_W-1:0] rd_addr;
    logic                  wr_en;
    logic [WORD_IDX_W-1:0] wr_addr;
  } ram_req_t;

endpackage

// ----- hdl/page_bitmap_allocator.sv -----
// Page bitmap allocator, first fit: top level with the request sequencer,
// result register and APB configuration register.
// Depends on pba_pkg and pba_bitmap_ram.
//
// Usage: one request transaction (mode_i, address_i, length_i) in, one
// result transaction (page_address_o, status_o) out. in_stall_o is high
// from acceptance until the result is loaded into the output register.
// Every request that passes its checks walks a page range [lo, hi] one
// bitmap word per cycle through one read-modify-write unit on the bitmap RAM:
//   single-page mark/free: one word read, modified and written back;
//   allocate: words scanned until a free page is found (up to 64);
//   region mark: every word the region spans (up to 64);
//   out-of-range page, empty region, zero page count: no RAM access.
// The RAM read port (one registered read per cycle) sets that rate.
// A finished result waits in the output register while the next request
// is taken; the sequencer only holds in its final state when a new result
// meets a result still stalled by the receiver.
// Reset marks every page used (no clearing pass: per-row valid bits) and
// sets page_count to 4096. Write page_count at byte address 0 only while
// no request is in flight.
module page_bitmap_allocator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // APB configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pba_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [pba_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [pba_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  // request channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         mode_i,
  input  logic [pba_pkg::ADDR_W-1:0]         address_i,
  input  logic [pba_pkg::ADDR_W-1:0]         length_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [pba_pkg::ADDR_W-1:0]         page_address_o,
  output logic [1:0]                         status_o
);
  import pba_pkg::*;

  state_e                state_q, state_d;
  mode_e                 mode_q, mode_d;
  logic [WORD_IDX_W-1:0] word_q, word_d;
  logic [PAGE_IDX_W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [ADDR_W-1:0]     res_addr_q, res_addr_d;
  status_e               res_status_q, res_status_d;
  logic [CNT_W-1:0]      page_count_q;
  logic                  out_valid_q;
  logic [ADDR_W-1:0]     out_addr_q;
  status_e               out_status_q;

  // ---------------- configuration ----------------
  logic cfg_write;
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= PAGE_COUNT_MAX;
    end else if (cfg_write && (paddr[2] == REG_PAGE_COUNT)) begin
      page_count_q <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PAGE_COUNT) begin
      prdata = APB_DATA_W'(page_count_q);
    end
  end

  // ---------------- request decode ----------------
  logic [CNT_W-1:0] limit;
  logic [PFN_W-1:0] req_page;
  logic [PFN_W:0]   region_sum;
  logic [CNT_W-1:0] region_end;
  logic             page_oor;
  logic             region_empty;
  logic [CNT_W-1:0] limit_m1;
  logic [CNT_W-1:0] region_end_m1;

  assign limit      = (page_count_q > PAGE_COUNT_MAX) ? PAGE_COUNT_MAX : page_count_q;
  assign req_page   = address_i[ADDR_W-1:PAGE_OFS_W];
  assign region_sum = {1'b0, req_page} + {1'b0, length_i[ADDR_W-1:PAGE_OFS_W]};
  assign region_end = (region_sum > (PFN_W+1)'(limit)) ? limit : region_sum[CNT_W-1:0];
  assign page_oor     = req_page >= PFN_W'(limit);
  assign region_empty = req_page >= PFN_W'(region_end);
  assign limit_m1      = limit - CNT_W'(1);
  assign region_end_m1 = region_end - CNT_W'(1);

  // ---------------- word unit ----------------
  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] lo_mask, hi_mask, range_mask;
  logic [WORD_BITS-1:0] free_bits, first_free, new_word;
  logic [BIT_IDX_W-1:0] free_idx;
  logic                 found;
  logic                 last_word;
  logic                 finish;
  ram_req_t             ram_req;

  assign lo_mask    = (word_q == lo_q[PAGE_IDX_W-1:BIT_IDX_W])
                      ? (WORD_ONES << lo_q[BIT_IDX_W-1:0]) : WORD_ONES;
  assign hi_mask    = (word_q == hi_q[PAGE_IDX_W-1:BIT_IDX_W])
                      ? (WORD_ONES >> (BIT_IDX_W'(WORD_BITS - 1) - hi_q[BIT_IDX_W-1:0]))
                      : WORD_ONES;
  assign range_mask = lo_mask & hi_mask;
  assign free_bits  = ~cur_word & range_mask;
  assign first_free = free_bits & (~free_bits + WORD_BITS'(1));
  assign found      = |free_bits;
  assign last_word  = word_q == hi_q[PAGE_IDX_W-1:BIT_IDX_W];

  always_comb begin
    free_idx = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        free_idx = BIT_IDX_W'(b);
      end
    end
  end

  always_comb begin
    case (mode_q)
      MODE_FREE:  new_word = cur_word & ~range_mask;
      MODE_ALLOC: new_word = cur_word | first_free;
      default:    new_word = cur_word | range_mask;
    endcase
  end

  assign finish = last_word || ((mode_q == MODE_ALLOC) && found);

  pba_bitmap_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (ram_req),
    .wr_data_i (new_word),
    .rd_data_o (cur_word)
  );

  // ---------------- sequencer: next state ----------------
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (mode_e'(mode_i))
            MODE_MARK, MODE_FREE: state_d = page_oor ? ST_DONE : ST_READ;
            MODE_ALLOC:           state_d = (limit == '0) ? ST_DONE : ST_READ;
            MODE_REGION:          state_d = region_empty ? ST_DONE : ST_READ;
            default:              state_d = ST_DONE;
          endcase
        end
      end
      ST_READ:   state_d = ST_MODIFY;
      ST_MODIFY: state_d = finish ? ST_DONE : ST_MODIFY;
      ST_DONE:   state_d = out_free ? ST_IDLE : ST_DONE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs and datapath ----------------
  always_comb begin
    mode_d       = mode_q;
    word_d       = word_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    res_addr_d   = res_addr_q;
    res_status_d = res_status_q;
    ram_req      = '0;
    in_stall_o   = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        mode_d       = mode_e'(mode_i);
        res_addr_d   = '0;
        res_status_d = STATUS_OK;
        unique case (mode_e'(mode_i))
          MODE_MARK, MODE_FREE: begin
            lo_d = req_page[PAGE_IDX_W-1:0];
            hi_d = req_page[PAGE_IDX_W-1:0];
            if (page_oor) begin
              res_status_d = STATUS_RANGE;
            end
          end
          MODE_ALLOC: begin
            lo_d = '0;
            hi_d = limit_m1[PAGE_IDX_W-1:0];
            if (limit == '0) begin
              res_status_d = STATUS_NO_FREE;
            end
          end
          default: begin
            lo_d = req_page[PAGE_IDX_W-1:0];
            hi_d = region_end_m1[PAGE_IDX_W-1:0];
          end
        endcase
        word_d = lo_d[PAGE_IDX_W-1:BIT_IDX_W];
      end
      ST_READ: begin
        ram_req.rd_en   = 1'b1;
        ram_req.rd_addr = word_q;
      end
      ST_MODIFY: begin
        ram_req.wr_addr = word_q;
        ram_req.wr_en   = (mode_q != MODE_ALLOC) || found;
        // stream the next word while this one is written back
        ram_req.rd_en   = !finish;
        ram_req.rd_addr = word_q + WORD_IDX_W'(1);
        if (!finish) begin
          word_d = word_q + WORD_IDX_W'(1);
        end
        if (mode_q == MODE_ALLOC) begin
          if (found) begin
            res_addr_d = ADDR_W'({word_q, free_idx}) << PAGE_OFS_W;
          end else if (last_word) begin
            res_status_d = STATUS_NO_FREE;
          end
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    word_q       <= word_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    res_addr_q   <= res_addr_d;
    res_status_q <= res_status_d;
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == ST_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DONE) && out_free) begin
      out_addr_q   <= res_addr_q;
      out_status_q <= res_status_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign page_address_o = out_addr_q;
  assign status_o       = out_status_q;

endmodule

// ----- hdl/pba_bitmap_ram.sv -----
// Bitmap word store for the page bitmap allocator: one 64-bit word per
// 64 pages, registered read. Rows never written read as all ones.
// Depends on pba_pkg.
module pba_bitmap_ram (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pba_pkg::ram_req_t               req_i,
  input  logic [pba_pkg::WORD_BITS-1:0]   wr_data_i,
  output logic [pba_pkg::WORD_BITS-1:0]   rd_data_o
);
  import pba_pkg::*;

  logic [WORD_BITS-1:0]  mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] row_valid_q;
  logic [WORD_BITS-1:0]  rd_data_q;
  logic                  rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= wr_data_i;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  // per-row valid bits stand in for the all-ones reset of the array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= row_valid_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_data_q : WORD_ONES;

endmodule

// ----- sim/tb_page_bitmap_allocator.sv -----
`timescale 1ns / 100ps
// Testbench for page_bitmap_allocator: random and directed requests against
// an in-bench bitmap predictor, APB page_count writes between phases.
// Depends on pba_pkg and the page_bitmap_allocator RTL.
module tb_page_bitmap_allocator;
  import pba_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_OFF_CYCLES = 500;
  localparam logic [APB_ADDR_W-1:0] PAGE_COUNT_ADDR = APB_ADDR_W'(4 * REG_PAGE_COUNT);
  localparam logic [ADDR_W-1:0] ADDR_ONES = '1;

  typedef struct packed {
    mode_e             mode;
    logic [ADDR_W-1:0] address;
    logic [ADDR_W-1:0] length;
  } page_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    status_e           status;
  } alloc_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [1:0]            mode_i = 2'b00;
  logic [ADDR_W-1:0]     address_i = '0;
  logic [ADDR_W-1:0]     length_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [ADDR_W-1:0]     page_address_o;
  logic [1:0]            status_o;

  page_bitmap_allocator u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .address_i      (address_i),
    .length_i       (length_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .page_address_o (page_address_o),
    .status_o       (status_o)
  );

  // bitmap mirror and configuration copy
  bit [PAGE_COUNT-1:0] used_map = '1;
  logic [CNT_W-1:0]    page_count_cfg = CNT_W'(PAGE_COUNT);

  page_req_t     requests_to_send[$];
  alloc_result_t awaited_results[$];
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   holds_asked = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // Applies one request to the mirror and returns the result it should give.
  function automatic alloc_result_t apply_to_bitmap(input page_req_t r);
    alloc_result_t   res;
    longint unsigned live;
    longint unsigned page;
    longint unsigned last;
    longint unsigned p;
    live = (page_count_cfg > PAGE_COUNT_MAX) ? PAGE_COUNT : page_count_cfg;
    page = r.address >> PAGE_OFS_W;
    res.page_address = '0;
    res.status = STATUS_OK;
    case (r.mode)
      MODE_MARK, MODE_FREE: begin
        if (page >= live) res.status = STATUS_RANGE;
        else used_map[page] = (r.mode == MODE_MARK);
      end
      MODE_ALLOC: begin
        res.status = STATUS_NO_FREE;
        for (p = 0; p < live; p++) begin
          if (!used_map[p]) begin
            used_map[p] = 1'b1;
            res.page_address = ADDR_W'(p << PAGE_OFS_W);
            res.status = STATUS_OK;
            break;
          end
        end
      end
      default: begin
        // region: whole pages only, clipped at the page count
        last = page + (r.length >> PAGE_OFS_W);
        if (last > live) last = live;
        for (p = page; p < last; p++) used_map[p] = 1'b1;
      end
    endcase
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  function automatic logic [ADDR_W-1:0] page_addr(input longint unsigned page);
    return {PFN_W'(page), PAGE_OFS_W'($urandom)};
  endfunction

  task automatic queue_request(input mode_e m, input logic [ADDR_W-1:0] a,
                               input logic [ADDR_W-1:0] len);
    page_req_t r;
    r.mode = m;
    r.address = a;
    r.length = len;
    requests_to_send.push_back(r);
  endtask

  function automatic page_req_t random_request(input int unsigned live);
    page_req_t   r;
    int unsigned pick;
    int unsigned page;
    pick = $urandom_range(0, 99);
    if (pick < 35) r.mode = MODE_FREE;
    else if (pick < 65) r.mode = MODE_ALLOC;
    else if (pick < 85) r.mode = MODE_MARK;
    else r.mode = MODE_REGION;
    r.length = rand48();
    pick = $urandom_range(0, 99);
    if (pick < 80) page = $urandom_range(0, live + 1);
    else page = ((live > 2) ? live - 2 : 0) + $urandom_range(0, 3);
    r.address = (pick < 90) ? page_addr(page) : rand48();
    if (r.mode == MODE_REGION) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) r.length = ADDR_W'($urandom_range(0, 9 * PAGE_BYTES - 1));
      else if (pick < 85) r.length = ADDR_W'($urandom_range(0, 64 * PAGE_BYTES));
      else if (pick < 95) r.length = ADDR_W'(longint'(live) * PAGE_BYTES);
    end
    return r;
  endfunction

  // Write page_count, then read it back; mirror updated at the write.
  task automatic write_page_count(input logic [CNT_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PAGE_COUNT_ADDR;
    pwdata  <= APB_DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    page_count_cfg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[CNT_W-1:0] !== value)
      flag_error($sformatf("page_count readback exp %0d got %0d", value, prdata[CNT_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // checked on the falling edge so all of the rising-edge updates have landed
  task automatic wait_idle();
    do @(negedge clk_i);
    while (requests_to_send.size() != 0 || in_valid_i || awaited_results.size() != 0);
  endtask

  // request driver: bursts with random gaps
  page_req_t   next_req;
  page_req_t   taken_req;
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i     <= MODE_MARK;
      address_i  <= '0;
      length_i   <= '0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        taken_req.mode = mode_e'(mode_i);
        taken_req.address = address_i;
        taken_req.length = length_i;
        awaited_results.push_back(apply_to_bitmap(taken_req));
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (requests_to_send.size() != 0) begin
          next_req = requests_to_send.pop_front();
          mode_i     <= next_req.mode;
          address_i  <= next_req.address;
          length_i   <= next_req.length;
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stall pattern
  alloc_result_t want;
  int unsigned   stall_pct;
  int unsigned   pattern_left;
  int unsigned   hold_left;
  int unsigned   holds_served;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      stall_pct    <= 0;
      pattern_left <= 0;
      hold_left    <= 0;
      holds_served <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          flag_error($sformatf("unexpected result: page_address %h status %0d",
                               page_address_o, status_o));
        end else begin
          want = awaited_results.pop_front();
          if (page_address_o !== want.page_address || status_o !== want.status)
            flag_error($sformatf("result mismatch: page_address exp %h got %h, status exp %0d got %0d",
                                 want.page_address, page_address_o, want.status, status_o));
        end
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if (holds_served < holds_asked) begin
        // long hold-off: lets the block back up into the request side
        holds_served <= holds_served + 1;
        hold_left    <= HOLD_OFF_CYCLES;
        out_stall_i  <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          pattern_left <= $urandom_range(16, 256);
          case ($urandom_range(0, 3))
            0: stall_pct <= 0;
            1: stall_pct <= 25;
            2: stall_pct <= 50;
            default: stall_pct <= 90;
          endcase
        end else begin
          pattern_left <= pattern_left - 1;
        end
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  logic [CNT_W-1:0] cfg_values [8] = '{13'd4096, 13'd0, 13'd1, 13'd64, 13'd65,
                                       13'h1FFF, 13'd4095, 13'd2};
  int unsigned      phase_items [8] = '{300, 30, 60, 200, 200, 250, 250, 240};

  initial begin
    int unsigned live;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    cfg_values[7] = CNT_W'($urandom_range(2, PAGE_COUNT));
    for (int ph = 0; ph < 8; ph++) begin
      write_page_count(cfg_values[ph]);
      live = (cfg_values[ph] > PAGE_COUNT_MAX) ? PAGE_COUNT : cfg_values[ph];
      if (ph == 0) begin
        // every page starts out used
        queue_request(MODE_ALLOC, rand48(), rand48());
        queue_request(MODE_FREE, page_addr(0), ADDR_ONES);
        queue_request(MODE_MARK, page_addr(0), '0);
        queue_request(MODE_FREE, page_addr(0), rand48());
        queue_request(MODE_ALLOC, ADDR_ONES, ADDR_ONES);
        queue_request(MODE_FREE, 48'hFF_FFFF, rand48());
        queue_request(MODE_ALLOC, '0, '0);  // full scan to the last page
        queue_request(MODE_ALLOC, rand48(), rand48());
        queue_request(MODE_MARK, 48'h100_0000, rand48());
        queue_request(MODE_FREE, ADDR_ONES, rand48());
        queue_request(MODE_FREE, page_addr(5), rand48());
        queue_request(MODE_FREE, page_addr(6), rand48());
        queue_request(MODE_FREE, page_addr(7), rand48());
        queue_request(MODE_FREE, page_addr(130), rand48());
        queue_request(MODE_REGION, page_addr(6), ADDR_W'(PAGE_BYTES - 1));
        queue_request(MODE_REGION, page_addr(6), ADDR_W'(PAGE_BYTES));
        queue_request(MODE_ALLOC, rand48(), rand48());
        queue_request(MODE_ALLOC, rand48(), rand48());
        queue_request(MODE_ALLOC, rand48(), rand48());
        queue_request(MODE_FREE, page_addr(4094), rand48());
        queue_request(MODE_FREE, page_addr(4095), rand48());
        queue_request(MODE_REGION, page_addr(4000), ADDR_ONES);
        queue_request(MODE_ALLOC, rand48(), rand48());
        queue_request(MODE_REGION, ADDR_ONES, ADDR_ONES);
        queue_request(MODE_REGION, '0, ADDR_ONES);
      end
      for (int i = 0; i < phase_items[ph]; i++)
        requests_to_send.push_back(random_request(live));
      if (ph == 0 || ph == 5) holds_asked++;
      wait_idle();
    end
    repeat (100) @(posedge clk_i);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
